FILE: rtl/core/assert_macros.svh
// Assertion macros shared by the RTL modules.
// Define NO_ASSERTIONS to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_CLK(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("forbidden condition seen");
`else
`define ASSERT_CLK(lbl, clk, rst, prop)
`define ASSERT_NEVER(lbl, clk, rst, expr)
`endif
`endif

FILE: rtl/core/fbpg_pkg.sv
// Types and constants of the framebuffer pattern generator.
// No dependencies.
package fbpg_pkg;

   localparam int MAX_DIM_DEFAULT = 4096;
   localparam int XW        = 12;
   localparam int DIMW      = 13;
   localparam int STRIDEW   = 16;
   localparam int PBW       = 4;
   localparam int OFFW      = 28;
   localparam int COLW      = 32;
   localparam int CSR_IDXW  = 3;
   localparam int CSR_DATAW = 32;
   localparam int DIV_STEPS = 12;
   localparam int GQW       = 8;
   localparam int GREMW     = 21;
   localparam int CMPW      = 26;

   typedef enum logic [1:0] {
      MODE_SOLID    = 2'd0,
      MODE_CHECKER  = 2'd1,
      MODE_GRADIENT = 2'd2
   } mode_type;

   typedef enum logic [CSR_IDXW-1:0] {
      REG_MODE    = 3'd0,
      REG_WIDTH   = 3'd1,
      REG_HEIGHT  = 3'd2,
      REG_STRIDE  = 3'd3,
      REG_PBYTES  = 3'd4,
      REG_TILE    = 3'd5,
      REG_COLOR_A = 3'd6,
      REG_COLOR_B = 3'd7
   } csr_idx_type;

   typedef struct packed {
      logic                vld;
      logic                wen;
      logic [1:0]          mode;
      logic [OFFW-1:0]     offset;
      logic [XW-1:0]       rtx;
      logic [XW-1:0]       rty;
      logic [GREMW-1:0]    rb;
      logic [GREMW-1:0]    rg;
      logic [GREMW-1:0]    rr;
      logic [GQW-1:0]      qb;
      logic [GQW-1:0]      qg;
      logic [GQW-1:0]      qr;
      logic                par;
      logic [COLW-1:0]     color;
   } stage_type;

endpackage

FILE: rtl/core/fbpg_if.sv
// Channel interfaces: pixel request, framebuffer write response, register write.
// Depends on fbpg_pkg.
interface fbpg_req_if;
   logic                         valid;
   logic                         ready;
   logic [fbpg_pkg::XW-1:0]      pixel_x;
   logic [fbpg_pkg::XW-1:0]      pixel_y;
   modport source (output valid, pixel_x, pixel_y, input ready);
   modport sink   (input valid, pixel_x, pixel_y, output ready);
endinterface

interface fbpg_rsp_if;
   logic                         valid;
   logic                         ready;
   logic                         write_enable;
   logic [fbpg_pkg::OFFW-1:0]    write_offset;
   logic [fbpg_pkg::COLW-1:0]    pixel_color;
   modport source (output valid, write_enable, write_offset, pixel_color, input ready);
   modport sink   (input valid, write_enable, write_offset, pixel_color, output ready);
endinterface

interface fbpg_csr_if;
   logic                            valid;
   logic                            ready;
   logic [fbpg_pkg::CSR_IDXW-1:0]   index;
   logic [fbpg_pkg::CSR_DATAW-1:0]  data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/core/framebuffer_pattern_generator_unit.sv
// Framebuffer test pattern generator, top level.
// Depends on fbpg_pkg, fbpg_if.sv and assert_macros.svh.
//
// Use: send one beat per pixel on req_bus (pixel_x, pixel_y). Each beat
// returns one beat on rsp_bus: write_enable, the byte offset y*stride+4x
// and the color. With write_enable low, offset and color are zero.
// Registers are written on csr_bus (index, data); csr_bus.ready is always
// high. Write them only while no pixel is in flight.
// Pipeline: 14 register stages. Throughput: one pixel per cycle while
// rsp_bus.ready does not stall it. The depth is set by the 12-step
// restoring divider chain (one quotient bit per stage for the tile and
// gradient quotients), plus an entry stage holding the offset multiply
// and a color select stage.
// Reset: all registers return to defaults (640x480, stride 2560, 4 bytes,
// tile 32, solid fill, black) and the pipeline empties.
// Stall: when rsp_bus.ready is low with a response waiting, the whole
// pipeline holds and req_bus.ready drops; nothing is lost or repeated.
`include "assert_macros.svh"

module framebuffer_pattern_generator_unit #(
   parameter int MAX_DIM = fbpg_pkg::MAX_DIM_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   fbpg_req_if.sink    req_bus,
   fbpg_rsp_if.source  rsp_bus,
   fbpg_csr_if.sink    csr_bus
);

   localparam int N    = fbpg_pkg::DIV_STEPS;
   localparam int LAST = N + 1;
   localparam logic [14:0] MaxDim = 15'(MAX_DIM);

   logic [1:0]                       mode_ff;
   logic [fbpg_pkg::DIMW-1:0]        width_ff;
   logic [fbpg_pkg::DIMW-1:0]        height_ff;
   logic [fbpg_pkg::STRIDEW-1:0]     stride_ff;
   logic [fbpg_pkg::PBW-1:0]         pbytes_ff;
   logic [fbpg_pkg::DIMW-1:0]        tile_ff;
   logic [fbpg_pkg::COLW-1:0]        color_a_ff;
   logic [fbpg_pkg::COLW-1:0]        color_b_ff;

   fbpg_pkg::stage_type pipe_ff [0:LAST];
   fbpg_pkg::stage_type pipe_in [0:LAST];

   logic                         advance;
   logic [fbpg_pkg::DIMW-1:0]    w_clamp;
   logic [fbpg_pkg::DIMW-1:0]    h_clamp;
   logic [fbpg_pkg::DIMW:0]      wh_sum;
   logic                         in_bounds;
   logic                         mode_ok;

   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= fbpg_pkg::MODE_SOLID;
         width_ff   <= 13'd640;
         height_ff  <= 13'd480;
         stride_ff  <= 16'd2560;
         pbytes_ff  <= 4'd4;
         tile_ff    <= 13'd32;
         color_a_ff <= '0;
         color_b_ff <= '0;
      end else if (csr_bus.valid) begin
         case (fbpg_pkg::csr_idx_type'(csr_bus.index))
            fbpg_pkg::REG_MODE:    mode_ff    <= csr_bus.data[1:0];
            fbpg_pkg::REG_WIDTH:   width_ff   <= csr_bus.data[fbpg_pkg::DIMW-1:0];
            fbpg_pkg::REG_HEIGHT:  height_ff  <= csr_bus.data[fbpg_pkg::DIMW-1:0];
            fbpg_pkg::REG_STRIDE:  stride_ff  <= csr_bus.data[fbpg_pkg::STRIDEW-1:0];
            fbpg_pkg::REG_PBYTES:  pbytes_ff  <= csr_bus.data[fbpg_pkg::PBW-1:0];
            fbpg_pkg::REG_TILE:    tile_ff    <= csr_bus.data[fbpg_pkg::DIMW-1:0];
            fbpg_pkg::REG_COLOR_A: color_a_ff <= csr_bus.data;
            fbpg_pkg::REG_COLOR_B: color_b_ff <= csr_bus.data;
            default: ;
         endcase
      end
   end

   assign w_clamp = ({2'b0, width_ff} > MaxDim) ? 13'(MAX_DIM) : width_ff;
   assign h_clamp = ({2'b0, height_ff} > MaxDim) ? 13'(MAX_DIM) : height_ff;
   assign wh_sum  = {1'b0, w_clamp} + {1'b0, h_clamp};

   assign advance       = !pipe_ff[LAST].vld || rsp_bus.ready;
   assign req_bus.ready = advance;

   // entry stage: bounds, offset multiply, dividends
   always_comb begin
      pipe_in[0] = '0;
      in_bounds = ({1'b0, req_bus.pixel_x} < w_clamp) && ({1'b0, req_bus.pixel_y} < h_clamp)
                  && (pbytes_ff == 4'd4);
      case (mode_ff)
         fbpg_pkg::MODE_SOLID:    mode_ok = 1'b1;
         fbpg_pkg::MODE_CHECKER:  mode_ok = (tile_ff != '0);
         fbpg_pkg::MODE_GRADIENT: mode_ok = 1'b1;
         default:                 mode_ok = 1'b0;
      endcase
      pipe_in[0].vld  = req_bus.valid;
      pipe_in[0].wen  = in_bounds && mode_ok;
      pipe_in[0].mode = mode_ff;
      pipe_in[0].offset = pipe_in[0].wen
         ? (28'(req_bus.pixel_y) * 28'(stride_ff) + 28'({req_bus.pixel_x, 2'b00}))
         : '0;
      pipe_in[0].rtx = req_bus.pixel_x;
      pipe_in[0].rty = req_bus.pixel_y;
      pipe_in[0].rb  = ({9'b0, req_bus.pixel_x} << 8) - {9'b0, req_bus.pixel_x};
      pipe_in[0].rg  = ({9'b0, req_bus.pixel_y} << 8) - {9'b0, req_bus.pixel_y};
      pipe_in[0].rr  = ({8'b0, {1'b0, req_bus.pixel_x} + {1'b0, req_bus.pixel_y}} << 8)
                       - {8'b0, {1'b0, req_bus.pixel_x} + {1'b0, req_bus.pixel_y}};
   end

   // restoring divider chain, one quotient bit per stage, MSB first
   for (genvar k = 1; k <= N; k++) begin : g_div
      localparam int B = N - k;
      logic [fbpg_pkg::CMPW-1:0] d_tile;
      logic [fbpg_pkg::CMPW-1:0] d_w;
      logic [fbpg_pkg::CMPW-1:0] d_h;
      logic [fbpg_pkg::CMPW-1:0] d_wh;
      logic ge_tx, ge_ty, ge_b, ge_g, ge_r;

      assign d_tile = fbpg_pkg::CMPW'(tile_ff) << B;
      assign d_w    = fbpg_pkg::CMPW'(w_clamp) << B;
      assign d_h    = fbpg_pkg::CMPW'(h_clamp) << B;
      assign d_wh   = fbpg_pkg::CMPW'(wh_sum) << B;

      always_comb begin
         pipe_in[k] = pipe_ff[k-1];
         ge_tx = fbpg_pkg::CMPW'(pipe_ff[k-1].rtx) >= d_tile;
         ge_ty = fbpg_pkg::CMPW'(pipe_ff[k-1].rty) >= d_tile;
         ge_b  = fbpg_pkg::CMPW'(pipe_ff[k-1].rb) >= d_w;
         ge_g  = fbpg_pkg::CMPW'(pipe_ff[k-1].rg) >= d_h;
         ge_r  = fbpg_pkg::CMPW'(pipe_ff[k-1].rr) >= d_wh;
         if (ge_tx) pipe_in[k].rtx = pipe_ff[k-1].rtx - d_tile[fbpg_pkg::XW-1:0];
         if (ge_ty) pipe_in[k].rty = pipe_ff[k-1].rty - d_tile[fbpg_pkg::XW-1:0];
         if (ge_b)  pipe_in[k].rb  = pipe_ff[k-1].rb - d_w[fbpg_pkg::GREMW-1:0];
         if (ge_g)  pipe_in[k].rg  = pipe_ff[k-1].rg - d_h[fbpg_pkg::GREMW-1:0];
         if (ge_r)  pipe_in[k].rr  = pipe_ff[k-1].rr - d_wh[fbpg_pkg::GREMW-1:0];
         pipe_in[k].qb  = {pipe_ff[k-1].qb[fbpg_pkg::GQW-2:0], ge_b};
         pipe_in[k].qg  = {pipe_ff[k-1].qg[fbpg_pkg::GQW-2:0], ge_g};
         pipe_in[k].qr  = {pipe_ff[k-1].qr[fbpg_pkg::GQW-2:0], ge_r};
         pipe_in[k].par = ge_tx ^ ge_ty;
      end
   end

   // color select
   always_comb begin
      pipe_in[LAST] = pipe_ff[N];
      case (pipe_ff[N].mode)
         fbpg_pkg::MODE_CHECKER:
            pipe_in[LAST].color = pipe_ff[N].par ? color_b_ff : color_a_ff;
         fbpg_pkg::MODE_GRADIENT:
            pipe_in[LAST].color = {8'hff, pipe_ff[N].qr, pipe_ff[N].qg, pipe_ff[N].qb};
         default:
            pipe_in[LAST].color = color_a_ff;
      endcase
      if (!pipe_ff[N].wen) pipe_in[LAST].color = '0;
   end

   for (genvar s = 0; s <= LAST; s++) begin : g_pipe
      always_ff @(posedge clock) begin
         if (reset) begin
            pipe_ff[s].vld <= 1'b0;
         end else if (advance) begin
            pipe_ff[s].vld <= pipe_in[s].vld;
         end
      end
      always_ff @(posedge clock) begin
         if (advance) begin
            pipe_ff[s].wen    <= pipe_in[s].wen;
            pipe_ff[s].mode   <= pipe_in[s].mode;
            pipe_ff[s].offset <= pipe_in[s].offset;
            pipe_ff[s].rtx    <= pipe_in[s].rtx;
            pipe_ff[s].rty    <= pipe_in[s].rty;
            pipe_ff[s].rb     <= pipe_in[s].rb;
            pipe_ff[s].rg     <= pipe_in[s].rg;
            pipe_ff[s].rr     <= pipe_in[s].rr;
            pipe_ff[s].qb     <= pipe_in[s].qb;
            pipe_ff[s].qg     <= pipe_in[s].qg;
            pipe_ff[s].qr     <= pipe_in[s].qr;
            pipe_ff[s].par    <= pipe_in[s].par;
            pipe_ff[s].color  <= pipe_in[s].color;
         end
      end
   end

   assign rsp_bus.valid        = pipe_ff[LAST].vld;
   assign rsp_bus.write_enable = pipe_ff[LAST].wen;
   assign rsp_bus.write_offset = pipe_ff[LAST].offset;
   assign rsp_bus.pixel_color  = pipe_ff[LAST].color;

   `ASSERT_CLK(a_off_zero, clock, reset,
      pipe_ff[LAST].vld && !pipe_ff[LAST].wen |->
      pipe_ff[LAST].offset == '0 && pipe_ff[LAST].color == '0)
   `ASSERT_CLK(a_grad_alpha, clock, reset,
      pipe_ff[LAST].vld && pipe_ff[LAST].wen && pipe_ff[LAST].mode == fbpg_pkg::MODE_GRADIENT
      |-> pipe_ff[LAST].color[31:24] == 8'hff)
   `ASSERT_CLK(a_vld_moves, clock, reset,
      advance && pipe_ff[0].vld |=> pipe_ff[1].vld)
   `ASSERT_NEVER(a_wen_mode3, clock, reset,
      pipe_ff[LAST].vld && pipe_ff[LAST].wen && pipe_ff[LAST].mode == 2'd3)

endmodule
